[sv/gf31m_pkg.sv]
// ----------------------------------------------------------------------------
// gf31m_pkg
// Shared types, constants and mod-31 helpers for the GF(31^2) multiply-
// accumulate block.
// ----------------------------------------------------------------------------
package gf31m_pkg;

    // Field prime and the value of x^2 in GF(31)[x]/(x^2 - 3).
    localparam int unsigned GF_P     = 31;
    localparam int unsigned X2_VALUE = 3;

    typedef logic [4:0] residue_t;

    // One registered request: both operands as residues, plus the end-of-sum mark.
    typedef struct packed {
        residue_t elem_const;
        residue_t elem_linear;
        residue_t coef_const;
        residue_t coef_linear;
        logic     last_term;
    } operand_t;

    // Maps a raw 5-bit operand to its residue: the code 31 stands for 0.
    function automatic residue_t to_residue(input logic [4:0] raw);
        residue_t res;
        res = (raw == residue_t'(GF_P)) ? residue_t'(0) : raw;
        return res;
    endfunction

    // Exact reduction of an 11-bit value mod 31, using 32 = 1 (mod 31).
    function automatic residue_t mod31(input logic [10:0] value);
        logic [6:0] fold1;
        logic [5:0] fold2;
        residue_t   res;
        fold1 = 7'(value[10:5]) + 7'(value[4:0]);
        fold2 = 6'(fold1[6:5]) + 6'(fold1[4:0]);
        if (fold2 >= 6'(GF_P))
        begin
            fold2 = fold2 - 6'(GF_P);
        end
        res = fold2[4:0];
        return res;
    endfunction

endpackage

[sv/gf31m_operand_stage.sv]
// ----------------------------------------------------------------------------
// gf31m_operand_stage
// Input register: takes one request, reduces the operands to residues and
// holds them until the accumulator stage consumes them.
// ----------------------------------------------------------------------------
module gf31m_operand_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [4:0]          elem_const,
    input  logic [4:0]          elem_linear,
    input  logic [4:0]          coef_const,
    input  logic [4:0]          coef_linear,
    input  logic                last_term,
    input  logic                advance,
    output logic                op_valid,
    output gf31m_pkg::operand_t op
);

    logic                valid_reg;
    logic                valid_next;
    gf31m_pkg::operand_t op_reg;
    logic                load;

    // The register is free when it is empty or its contents move on this cycle.
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Control bit with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded only when a request is taken.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg.elem_const  <= gf31m_pkg::to_residue(elem_const);
            op_reg.elem_linear <= gf31m_pkg::to_residue(elem_linear);
            op_reg.coef_const  <= gf31m_pkg::to_residue(coef_const);
            op_reg.coef_linear <= gf31m_pkg::to_residue(coef_linear);
            op_reg.last_term   <= last_term;
        end
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

[sv/gf31m_accumulator.sv]
// ----------------------------------------------------------------------------
// gf31m_accumulator
// Multiplies the two GF(31^2) operands, adds the partial products into the
// three mod-31 accumulators and forms the reduced sum for the last term.
// ----------------------------------------------------------------------------
module gf31m_accumulator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  gf31m_pkg::operand_t op,
    output logic [4:0]          sum_const,
    output logic [4:0]          sum_linear
);

    gf31m_pkg::residue_t acc_const_reg;
    gf31m_pkg::residue_t acc_linear_reg;
    gf31m_pkg::residue_t acc_square_reg;
    gf31m_pkg::residue_t acc_const_next;
    gf31m_pkg::residue_t acc_linear_next;
    gf31m_pkg::residue_t acc_square_next;
    gf31m_pkg::residue_t new_const;
    gf31m_pkg::residue_t new_linear;
    gf31m_pkg::residue_t new_square;
    logic [9:0]          prod_cc;
    logic [9:0]          prod_cl;
    logic [9:0]          prod_lc;
    logic [9:0]          prod_ll;
    logic [6:0]          fold_sum;

    // Four 5x5 partial products of the field multiplication.
    assign prod_cc = 10'(op.elem_const)  * 10'(op.coef_const);
    assign prod_cl = 10'(op.elem_const)  * 10'(op.coef_linear);
    assign prod_lc = 10'(op.elem_linear) * 10'(op.coef_const);
    assign prod_ll = 10'(op.elem_linear) * 10'(op.coef_linear);

    // Accumulate with exact reduction.
    assign new_const  = gf31m_pkg::mod31(11'(acc_const_reg) + 11'(prod_cc));
    assign new_linear = gf31m_pkg::mod31(11'(acc_linear_reg) + 11'(prod_cl)
                                         + 11'(prod_lc));
    assign new_square = gf31m_pkg::mod31(11'(acc_square_reg) + 11'(prod_ll));

    // Fold the x^2 part into the constant part: x^2 = 3.
    assign fold_sum   = 7'(new_const) + 7'(gf31m_pkg::X2_VALUE) * 7'(new_square);
    assign sum_const  = gf31m_pkg::mod31(11'(fold_sum));
    assign sum_linear = new_linear;

    // Next accumulator values: cleared after the last term.
    always_comb
    begin
        acc_const_next  = acc_const_reg;
        acc_linear_next = acc_linear_reg;
        acc_square_next = acc_square_reg;
        if (step)
        begin
            if (op.last_term)
            begin
                acc_const_next  = '0;
                acc_linear_next = '0;
                acc_square_next = '0;
            end
            else
            begin
                acc_const_next  = new_const;
                acc_linear_next = new_linear;
                acc_square_next = new_square;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_const_reg  <= '0;
            acc_linear_reg <= '0;
            acc_square_reg <= '0;
        end
        else
        begin
            acc_const_reg  <= acc_const_next;
            acc_linear_reg <= acc_linear_next;
            acc_square_reg <= acc_square_next;
        end
    end

    // The accumulators always hold proper residues.
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        acc_const_reg < 5'd31 && acc_linear_reg < 5'd31 && acc_square_reg < 5'd31)
        else $error("accumulator holds an unreduced value");

    // A last term leaves all accumulators cleared.
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && op.last_term |=>
            acc_const_reg == '0 && acc_linear_reg == '0 && acc_square_reg == '0)
        else $error("accumulators not cleared after the last term");

    // Without a step the accumulators hold.
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(acc_const_reg) && $stable(acc_linear_reg)
                  && $stable(acc_square_reg))
        else $error("accumulator changed without a step");

endmodule

[sv/gf31m_result_stage.sv]
// ----------------------------------------------------------------------------
// gf31m_result_stage
// Output register: holds one finished sum until the receiver takes it.
// ----------------------------------------------------------------------------
module gf31m_result_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [4:0] sum_const_in,
    input  logic [4:0] sum_linear_in,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [4:0] sum_const,
    output logic [4:0] sum_linear,
    output logic       advance
);

    logic       valid_reg;
    logic       valid_next;
    logic [4:0] sum_const_reg;
    logic [4:0] sum_linear_reg;

    // The stage can take a new sum unless a held one is stalled.
    assign advance = !(valid_reg && out_stall);

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_const_reg  <= sum_const_in;
            sum_linear_reg <= sum_linear_in;
        end
    end

    assign out_valid  = valid_reg;
    assign sum_const  = sum_const_reg;
    assign sum_linear = sum_linear_reg;

endmodule

[sv/gf31_quadratic_ext_mac.sv]
// ----------------------------------------------------------------------------
// gf31_quadratic_ext_mac
// Multiply-accumulate over GF(31^2) with x^2 = 3, one term per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request carries one matrix element (elem_const, elem_linear),
//   one vector element (coef_const, coef_linear) and last_term. An operand
//   code of 31 counts as zero. Requests are taken on in_valid with in_stall
//   low; results leave on out_valid with out_stall low.
//   Every request adds its product into three mod-31 accumulators. A request
//   with last_term set produces one result request, (const + 3 * square) and
//   linear, and clears the accumulators for the next sum.
//   Throughput, set by the accumulator loop, is one request per cycle while
//   the receiver does not stall a held result. A last term waits in the
//   input register, and its sum is then loaded into the result register.
//   Reset clears the accumulators and both valid bits. When the receiver
//   stalls a held result, the pipeline freezes and in_stall rises once the
//   input register is also occupied; no request is lost or repeated.
// ----------------------------------------------------------------------------
module gf31_quadratic_ext_mac (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] elem_const,
    input  logic [4:0] elem_linear,
    input  logic [4:0] coef_const,
    input  logic [4:0] coef_linear,
    input  logic       last_term,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] sum_const,
    output logic [4:0] sum_linear
);

    gf31m_pkg::operand_t op;
    logic                op_valid;
    logic                advance;
    logic                step;
    logic [4:0]          acc_sum_const;
    logic [4:0]          acc_sum_linear;

    // The registered term is consumed whenever the result side can move.
    assign step = op_valid && advance;

    gf31m_operand_stage u_operand (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .elem_const  (elem_const),
        .elem_linear (elem_linear),
        .coef_const  (coef_const),
        .coef_linear (coef_linear),
        .last_term   (last_term),
        .advance     (advance),
        .op_valid    (op_valid),
        .op          (op)
    );

    gf31m_accumulator u_accumulator (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .op         (op),
        .sum_const  (acc_sum_const),
        .sum_linear (acc_sum_linear)
    );

    gf31m_result_stage u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step && op.last_term),
        .sum_const_in  (acc_sum_const),
        .sum_linear_in (acc_sum_linear),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .sum_const     (sum_const),
        .sum_linear    (sum_linear),
        .advance       (advance)
    );

endmodule
